/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, cancelled while reset is low
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// same-cycle implication on top of the clocked form
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  `ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons))

`endif

/* design/jceg_pkg.sv */
`timescale 1ns / 1ps

package jceg_pkg;

  localparam int unsigned MAX_AXES    = 8;
  localparam int unsigned MAX_BUTTONS = 32;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned THR_W       = 15;
  localparam int unsigned PEND_W      = 1 + MAX_AXES + MAX_BUTTONS;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned IN_TDATA_W  = 176;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned POS_LSB     = 44;

  localparam logic [THR_W-1:0] THR_RESET = 15'd26;

  typedef enum logic [2:0] {
    EV_CONNECTED    = 3'd0,
    EV_DISCONNECTED = 3'd1,
    EV_MOVED        = 3'd2,
    EV_PRESSED      = 3'd3,
    EV_RELEASED     = 3'd4
  } event_kind_e;

  typedef struct packed {
    logic [2:0]                     joy;
    logic                           conn;
    logic [MAX_AXES-1:0]            present;
    logic [MAX_BUTTONS-1:0]         buttons;
    logic [MAX_AXES-1:0][POS_W-1:0] pos;
  } snap_t;

  // one snapshot worth of pending events
  typedef struct packed {
    logic [2:0]                     joy;
    logic                           conn;
    logic                           conn_chg;
    logic [MAX_AXES-1:0]            move;
    logic [MAX_AXES-1:0][POS_W-1:0] pos;
    logic [MAX_BUTTONS-1:0]         btn_chg;
    logic [MAX_BUTTONS-1:0]         btn_new;
  } desc_t;

endpackage

/* design/jceg_front.sv */
`timescale 1ns / 1ps

module jceg_front #(
  parameter int unsigned NUM_JOYSTICKS = 8,
  parameter int unsigned NUM_AXES      = 8,
  parameter int unsigned NUM_BUTTONS   = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [jceg_pkg::THR_W-1:0]   cfg_wdata_i,
  input  logic                         snap_valid_i,
  output logic                         snap_ready_o,
  input  jceg_pkg::snap_t              snap_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output jceg_pkg::desc_t              desc_o
);

  localparam int unsigned JoyW   = (NUM_JOYSTICKS > 1) ? $clog2(NUM_JOYSTICKS) : 1;
  localparam logic [4:0]  NumJoy = 5'(NUM_JOYSTICKS);
  localparam int unsigned PosW   = jceg_pkg::POS_W;

  logic [jceg_pkg::THR_W-1:0] thr_q;
  logic [NUM_JOYSTICKS-1:0]   was_conn_q;
  logic [NUM_BUTTONS-1:0]     btn_q  [NUM_JOYSTICKS];
  // one row of reported positions per joystick
  logic [NUM_AXES-1:0][PosW-1:0] axis_q [NUM_JOYSTICKS];

  logic [3:0]                 joy_ext;
  logic [JoyW-1:0]            jidx;
  logic                       in_range;
  logic                       accept;
  logic                       old_conn;
  logic                       conn_rise;
  logic [jceg_pkg::MAX_BUTTONS-1:0] btn_new;
  logic [jceg_pkg::MAX_BUTTONS-1:0] btn_old;
  logic [PosW-1:0]            prev_pos [NUM_AXES];
  logic signed [PosW:0]       diff     [NUM_AXES];
  logic [PosW:0]              mag      [NUM_AXES];
  logic                       any_event;

  assign snap_ready_o = push_ready_i;

  always_comb begin
    joy_ext   = {1'b0, snap_i.joy};
    jidx      = joy_ext[JoyW-1:0];
    in_range  = {2'b00, snap_i.joy} < NumJoy;
    accept    = snap_valid_i && push_ready_i;
    old_conn  = was_conn_q[jidx];
    conn_rise = snap_i.conn && !old_conn;

    btn_new = '0;
    btn_old = '0;
    btn_new[NUM_BUTTONS-1:0] = snap_i.buttons[NUM_BUTTONS-1:0];
    btn_old[NUM_BUTTONS-1:0] = btn_q[jidx];

    desc_o          = '0;
    desc_o.joy      = snap_i.joy;
    desc_o.conn     = snap_i.conn;
    desc_o.conn_chg = snap_i.conn != old_conn;
    desc_o.pos      = snap_i.pos;
    desc_o.btn_new  = btn_new;
    desc_o.btn_chg  = snap_i.conn ? (btn_new ^ btn_old) : '0;

    // a connect starts every axis from zero again
    for (int a = 0; a < NUM_AXES; a++) begin
      prev_pos[a]    = conn_rise ? '0 : axis_q[jidx][a];
      diff[a]        = $signed({snap_i.pos[a][PosW-1], snap_i.pos[a]})
                     - $signed({prev_pos[a][PosW-1], prev_pos[a]});
      mag[a]         = diff[a][PosW] ? (PosW+1)'(-diff[a]) : (PosW+1)'(diff[a]);
      desc_o.move[a] = snap_i.conn && snap_i.present[a] && (mag[a] >= {2'b00, thr_q});
    end

    any_event    = desc_o.conn_chg || (|desc_o.move) || (|desc_o.btn_chg);
    push_valid_o = accept && in_range && any_event;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= jceg_pkg::THR_RESET;
      was_conn_q <= '0;
      for (int j = 0; j < NUM_JOYSTICKS; j++) begin
        btn_q[j]  <= '0;
        axis_q[j] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (accept && in_range) begin
        was_conn_q[jidx] <= snap_i.conn;
        btn_q[jidx]      <= btn_new[NUM_BUTTONS-1:0];
        if (snap_i.conn) begin
          for (int a = 0; a < NUM_AXES; a++) begin
            axis_q[jidx][a] <= desc_o.move[a] ? snap_i.pos[a] : prev_pos[a];
          end
        end
      end
    end
  end

endmodule

/* design/jceg_queue.sv */
`timescale 1ns / 1ps

module jceg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  jceg_pkg::desc_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output jceg_pkg::desc_t pop_data_o
);

  localparam int unsigned Depth = jceg_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  jceg_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  always_comb begin
    push_ready_o = count_q != CntW'(Depth);
    pop_valid_o  = count_q != '0;
    pop_data_o   = mem_q[rd_ptr_q];
    do_push      = push_valid_i && push_ready_o;
    do_pop       = pop_valid_o && pop_ready_i;

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end

    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* design/jceg_back.sv */
`timescale 1ns / 1ps

module jceg_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              pop_valid_i,
  output logic                              pop_ready_o,
  input  jceg_pkg::desc_t                   pop_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output jceg_pkg::event_kind_e             out_kind_o,
  output logic [2:0]                        out_joy_o,
  output logic [4:0]                        out_item_o,
  output logic [jceg_pkg::POS_W-1:0]        out_pos_o,
  output logic                              out_last_o
);

  localparam int unsigned PendW = jceg_pkg::PEND_W;
  localparam int unsigned NAx   = jceg_pkg::MAX_AXES;
  localparam int unsigned NBt   = jceg_pkg::MAX_BUTTONS;

  jceg_pkg::desc_t       work_q, work_d;
  logic [PendW-1:0]      pend_q, pend_d;
  logic                  work_v_q, work_v_d;

  logic                  out_v_q, out_v_d;
  jceg_pkg::event_kind_e kind_q, kind_d;
  logic [2:0]            joy_q, joy_d;
  logic [4:0]            item_q, item_d;
  logic [jceg_pkg::POS_W-1:0] pos_q, pos_d;
  logic                  last_q, last_d;

  logic                  advance, emit, fin, load;
  logic [PendW-1:0]      low, rest;

  always_comb begin
    advance = !out_v_q || out_ready_i;
    emit    = advance && work_v_q;
    // isolate the lowest pending event
    low     = pend_q & (~pend_q + 1'b1);
    rest    = pend_q & ~low;
    fin     = rest == '0;

    pop_ready_o = !work_v_q || (emit && fin);
    load        = pop_valid_i && pop_ready_o;

    work_d   = work_q;
    pend_d   = pend_q;
    work_v_d = work_v_q;
    if (load) begin
      work_d   = pop_data_i;
      pend_d   = {pop_data_i.btn_chg, pop_data_i.move, pop_data_i.conn_chg};
      work_v_d = 1'b1;
    end else if (emit) begin
      pend_d = rest;
      if (fin) begin
        work_v_d = 1'b0;
      end
    end

    item_d = '0;
    pos_d  = '0;
    for (int i = 0; i < NAx; i++) begin
      if (low[1 + i]) begin
        item_d = item_d | 5'(i);
        pos_d  = pos_d | work_q.pos[i];
      end
    end
    for (int b = 0; b < NBt; b++) begin
      if (low[1 + NAx + b]) begin
        item_d = item_d | 5'(b);
      end
    end

    if (low[0]) begin
      kind_d = work_q.conn ? jceg_pkg::EV_CONNECTED : jceg_pkg::EV_DISCONNECTED;
    end else if (|low[NAx:1]) begin
      kind_d = jceg_pkg::EV_MOVED;
    end else if ((work_q.btn_new & low[PendW-1:NAx+1]) != '0) begin
      kind_d = jceg_pkg::EV_PRESSED;
    end else begin
      kind_d = jceg_pkg::EV_RELEASED;
    end
    joy_d  = work_q.joy;
    last_d = fin;

    out_v_d = out_v_q;
    if (emit) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      work_v_q <= work_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    pend_q <= pend_d;
    if (emit) begin
      kind_q <= kind_d;
      joy_q  <= joy_d;
      item_q <= item_d;
      pos_q  <= pos_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_kind_o  = kind_q;
  assign out_joy_o   = joy_q;
  assign out_item_o  = item_q;
  assign out_pos_o   = pos_q;
  assign out_last_o  = last_q;

endmodule

/* design/joystick_change_event_generator.sv */
// Joystick change-event generator: each input beat is one poll snapshot of one joystick,
// and the block emits the connect/disconnect, axis move (dead band set by the threshold
// register) and button press/release events it causes, one event beat per cycle while
// the output is not stalled, with tlast on the final event of the snapshot; snapshots
// that change nothing emit nothing. The front end classifies a snapshot in the cycle it
// is accepted and updates the per-joystick state at once, so a new snapshot can be
// taken every cycle while the two-entry event queue has room. The back end drains one
// event per cycle while the output is not stalled, so a snapshot's events (1 to 41)
// leave one after another; sustained rate is set by that serial drain. Input tdata,
// lowest bit up: joy_index[2:0], connected[3], axis_present[11:4], buttons[43:12],
// axis_pos_0..7 at [59:44] up to [171:156], zero pad to 176. Output tdata:
// event_joy[2:0], item_index[7:3], new_position[23:8]; tuser carries event_kind.
`timescale 1ns / 1ps

module joystick_change_event_generator #(
  parameter int unsigned NUM_JOYSTICKS = 8,
  parameter int unsigned NUM_AXES      = 8,
  parameter int unsigned NUM_BUTTONS   = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [jceg_pkg::THR_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // joy_index, connected, axis_present, buttons, axis_pos_0 .. axis_pos_7, pad
  input  logic [jceg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // event_joy, item_index, new_position
  output logic [jceg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // event_kind
  output logic [2:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  localparam int unsigned PosW = jceg_pkg::POS_W;

  jceg_pkg::snap_t       snap;
  jceg_pkg::desc_t       push_desc, pop_desc;
  logic                  push_valid, push_ready;
  logic                  pop_valid, pop_ready;
  jceg_pkg::event_kind_e out_kind;
  logic [2:0]            out_joy;
  logic [4:0]            out_item;
  logic [PosW-1:0]       out_pos;

  always_comb begin
    snap.joy     = s_axis_tdata[2:0];
    snap.conn    = s_axis_tdata[3];
    snap.present = s_axis_tdata[11:4];
    snap.buttons = s_axis_tdata[43:12];
    for (int a = 0; a < jceg_pkg::MAX_AXES; a++) begin
      snap.pos[a] = s_axis_tdata[jceg_pkg::POS_LSB + PosW*a +: PosW];
    end
  end

  jceg_front #(
    .NUM_JOYSTICKS (NUM_JOYSTICKS),
    .NUM_AXES      (NUM_AXES),
    .NUM_BUTTONS   (NUM_BUTTONS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .snap_valid_i (s_axis_tvalid),
    .snap_ready_o (s_axis_tready),
    .snap_i       (snap),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .desc_o       (push_desc)
  );

  jceg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_desc),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_desc)
  );

  jceg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_desc),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (out_kind),
    .out_joy_o   (out_joy),
    .out_item_o  (out_item),
    .out_pos_o   (out_pos),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_pos, out_item, out_joy};
  assign m_axis_tuser = out_kind;

endmodule

/* design/jceg_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jceg_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [jceg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [2:0]                       m_axis_tuser,
  input logic                             m_axis_tlast
);

  logic                               out_stall;
  logic                               out_mid;
  logic                               conn_beat;
  logic                               other_beat;
  logic [jceg_pkg::OUT_TDATA_W+3:0]   out_beat;

  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_mid    = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
  assign conn_beat  = m_axis_tvalid && (m_axis_tuser == jceg_pkg::EV_CONNECTED ||
                                        m_axis_tuser == jceg_pkg::EV_DISCONNECTED);
  assign other_beat = m_axis_tvalid && (m_axis_tuser != jceg_pkg::EV_MOVED);
  assign out_beat   = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // a stalled event beat holds still
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_stall |=> (m_axis_tvalid && $stable(out_beat)))

  // the rest of a snapshot's events follow without a gap
  `ASSERT_CLK(a_burst_gapless, clk_i, rst_ni, out_mid |=> m_axis_tvalid)

  // connect and disconnect carry no item and no position
  `ASSERT_IMPL(a_conn_fields, clk_i, rst_ni, conn_beat, m_axis_tdata[23:3] == '0)

  // only move events carry a position
  `ASSERT_IMPL(a_pos_only_move, clk_i, rst_ni, other_beat, m_axis_tdata[23:8] == '0)

endmodule

bind joystick_change_event_generator jceg_checker u_checker (.*);
